[rtl/vmbm_pkg.sv]
// Package for the video memory bank mapper: bank and region codes, write masks,
// the per-bank window decode and the shared types. No dependencies.
`timescale 1ns / 1ps

package vmbm_pkg;

  localparam int BANK_COUNT = 9;

  typedef logic [7:0] ctl_t;
  typedef logic [BANK_COUNT-1:0][7:0] ctl_bank_t;
  typedef logic [BANK_COUNT-1:0] hit_t;

  // Write request towards the bank control registers.
  typedef struct packed {
    logic       en;
    logic [3:0] index;
    logic [7:0] value;
  } bank_wr_t;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [3:0] BANK_A = 4'd0;
  localparam logic [3:0] BANK_B = 4'd1;
  localparam logic [3:0] BANK_C = 4'd2;
  localparam logic [3:0] BANK_D = 4'd3;
  localparam logic [3:0] BANK_E = 4'd4;
  localparam logic [3:0] BANK_F = 4'd5;
  localparam logic [3:0] BANK_G = 4'd6;
  localparam logic [3:0] BANK_H = 4'd7;
  localparam logic [3:0] BANK_I = 4'd8;

  localparam logic [3:0] REG_LCDC      = 4'd0;
  localparam logic [3:0] REG_BG_A      = 4'd1;
  localparam logic [3:0] REG_OBJ_A     = 4'd2;
  localparam logic [3:0] REG_BG_B      = 4'd3;
  localparam logic [3:0] REG_OBJ_B     = 4'd4;
  localparam logic [3:0] REG_SUB_CPU   = 4'd5;
  localparam logic [3:0] REG_TEX       = 4'd6;
  localparam logic [3:0] REG_TEX_PAL   = 4'd7;
  localparam logic [3:0] REG_BG_A_EXT  = 4'd8;
  localparam logic [3:0] REG_BG_B_EXT  = 4'd9;
  localparam logic [3:0] REG_OBJ_A_EXT = 4'd10;
  localparam logic [3:0] REG_OBJ_B_EXT = 4'd11;

  localparam logic [2:0] MODE_LCDC = 3'd0;
  localparam logic [2:0] MODE_1    = 3'd1;
  localparam logic [2:0] MODE_2    = 3'd2;
  localparam logic [2:0] MODE_3    = 3'd3;
  localparam logic [2:0] MODE_4    = 3'd4;
  localparam logic [2:0] MODE_5    = 3'd5;

  localparam logic [7:0] SUB_STATUS_MASK  = 8'h87;
  localparam logic [7:0] SUB_STATUS_MATCH = 8'h82;

  localparam logic [19:0] SIZE_128K = 20'h20000;
  localparam logic [19:0] SIZE_64K  = 20'h10000;
  localparam logic [19:0] SIZE_32K  = 20'h08000;
  localparam logic [19:0] SIZE_16K  = 20'h04000;
  localparam logic [19:0] SIZE_8K   = 20'h02000;

  function automatic ctl_t write_mask(input logic [3:0] b);
    case (b)
      BANK_A, BANK_B:                 return 8'h9b;
      BANK_C, BANK_D, BANK_F, BANK_G: return 8'h9f;
      BANK_E:                         return 8'h87;
      BANK_H, BANK_I:                 return 8'h83;
      default:                        return 8'h00;
    endcase
  endfunction

  function automatic logic [19:0] lcdc_base(input logic [3:0] b);
    case (b)
      BANK_A:  return 20'h00000;
      BANK_B:  return 20'h20000;
      BANK_C:  return 20'h40000;
      BANK_D:  return 20'h60000;
      BANK_E:  return 20'h80000;
      BANK_F:  return 20'h90000;
      BANK_G:  return 20'h94000;
      BANK_H:  return 20'h98000;
      BANK_I:  return 20'ha0000;
      default: return 20'h00000;
    endcase
  endfunction

  function automatic logic [19:0] lcdc_size(input logic [3:0] b);
    case (b)
      BANK_A, BANK_B, BANK_C, BANK_D: return SIZE_128K;
      BANK_E:                         return SIZE_64K;
      BANK_F, BANK_G, BANK_I:         return SIZE_16K;
      BANK_H:                         return SIZE_32K;
      default:                        return 20'h00000;
    endcase
  endfunction

  // True when bank b, with control byte ctl, maps region rgn and covers addr.
  function automatic logic bank_hit(input logic [3:0] b, input ctl_t ctl,
                                    input logic [3:0] rgn, input logic [19:0] addr);
    logic [2:0]  mode;
    logic [1:0]  ofs;
    logic        mapped;
    logic [3:0]  rg;
    logic [19:0] base;
    logic [19:0] size;
    mode   = ctl[2:0];
    ofs    = ctl[4:3];
    mapped = 1'b0;
    rg     = REG_LCDC;
    base   = '0;
    size   = '0;
    if (ctl[7]) begin
      if (mode == MODE_LCDC) begin
        mapped = 1'b1;
        base   = lcdc_base(b);
        size   = lcdc_size(b);
      end else begin
        case (b)
          BANK_A, BANK_B, BANK_C, BANK_D: begin
            size = SIZE_128K;
            case (mode)
              MODE_1: begin
                mapped = 1'b1; rg = REG_BG_A; base = {1'b0, ofs, 17'b0};
              end
              MODE_2: begin
                mapped = 1'b1;
                rg     = (b == BANK_A || b == BANK_B) ? REG_OBJ_A : REG_SUB_CPU;
                base   = {2'b0, ofs[0], 17'b0};
              end
              MODE_3: begin
                mapped = 1'b1; rg = REG_TEX; base = {1'b0, ofs, 17'b0};
              end
              MODE_4: begin
                mapped = (b == BANK_C || b == BANK_D);
                rg     = (b == BANK_C) ? REG_BG_B : REG_OBJ_B;
              end
              default: mapped = 1'b0;
            endcase
          end
          BANK_E: begin
            size = SIZE_64K;
            case (mode)
              MODE_1:  begin mapped = 1'b1; rg = REG_BG_A; end
              MODE_2:  begin mapped = 1'b1; rg = REG_OBJ_A; end
              MODE_3:  begin mapped = 1'b1; rg = REG_TEX_PAL; end
              MODE_4:  begin mapped = 1'b1; rg = REG_BG_A_EXT; size = SIZE_32K; end
              default: mapped = 1'b0;
            endcase
          end
          BANK_F, BANK_G: begin
            size = SIZE_16K;
            case (mode)
              MODE_1: begin
                mapped = 1'b1; rg = REG_BG_A; base = {3'b0, ofs[1], 1'b0, ofs[0], 14'b0};
              end
              MODE_2: begin
                mapped = 1'b1; rg = REG_OBJ_A; base = {3'b0, ofs[1], 1'b0, ofs[0], 14'b0};
              end
              MODE_3: begin
                mapped = 1'b1; rg = REG_TEX_PAL;
                base   = {3'b0, ofs[1], 1'b0, ofs[0], 14'b0};
              end
              MODE_4: begin
                mapped = 1'b1; rg = REG_BG_A_EXT; base = {5'b0, ofs[0], 14'b0};
              end
              MODE_5:  begin mapped = 1'b1; rg = REG_OBJ_A_EXT; size = SIZE_8K; end
              default: mapped = 1'b0;
            endcase
          end
          BANK_H: begin
            size = SIZE_32K;
            case (mode)
              MODE_1:  begin mapped = 1'b1; rg = REG_BG_B; end
              MODE_2:  begin mapped = 1'b1; rg = REG_BG_B_EXT; end
              default: mapped = 1'b0;
            endcase
          end
          BANK_I: begin
            size = SIZE_16K;
            case (mode)
              MODE_1:  begin mapped = 1'b1; rg = REG_BG_B; base = 20'h08000; end
              MODE_2:  begin mapped = 1'b1; rg = REG_OBJ_B; end
              MODE_3:  begin mapped = 1'b1; rg = REG_OBJ_B_EXT; size = SIZE_8K; end
              default: mapped = 1'b0;
            endcase
          end
          default: mapped = 1'b0;
        endcase
      end
    end
    return mapped && (rg == rgn) && (addr >= base) && ((addr - base) < size);
  endfunction

endpackage

[rtl/vmbm_bank_file.sv]
// Bank control registers A to I with write masking and the sub-processor status.
// Depends on vmbm_pkg.
`timescale 1ns / 1ps

module vmbm_bank_file (
  input  logic                clk,
  input  logic                rst,
  input  vmbm_pkg::bank_wr_t  wr,
  output vmbm_pkg::ctl_bank_t controls,
  output vmbm_pkg::ctl_t      masked_value,
  output logic [1:0]          status_next
);

  vmbm_pkg::ctl_bank_t controls_next;

  assign masked_value = wr.value & vmbm_pkg::write_mask(wr.index);

  always_comb begin
    controls_next = controls;
    for (int b = 0; b < vmbm_pkg::BANK_COUNT; b++) begin
      if (wr.en && wr.index == 4'(b)) begin
        controls_next[b] = masked_value;
      end
    end
  end

  // The status reflects the registers as they stand after this transfer's write.
  assign status_next[0] = (controls_next[vmbm_pkg::BANK_C] & vmbm_pkg::SUB_STATUS_MASK)
                          == vmbm_pkg::SUB_STATUS_MATCH;
  assign status_next[1] = (controls_next[vmbm_pkg::BANK_D] & vmbm_pkg::SUB_STATUS_MASK)
                          == vmbm_pkg::SUB_STATUS_MATCH;

  always_ff @(posedge clk) begin
    if (rst) begin
      controls <= '0;
    end else begin
      controls <= controls_next;
    end
  end

endmodule

[rtl/vmbm_lookup.sv]
// Parallel window decode of all nine banks for one region address.
// Depends on vmbm_pkg.
`timescale 1ns / 1ps

module vmbm_lookup (
  input  vmbm_pkg::ctl_bank_t controls,
  input  logic [3:0]          region_id,
  input  logic [19:0]         region_address,
  output vmbm_pkg::hit_t      hits
);

  always_comb begin
    for (int b = 0; b < vmbm_pkg::BANK_COUNT; b++) begin
      hits[b] = vmbm_pkg::bank_hit(4'(b), controls[b], region_id, region_address);
    end
  end

endmodule

[rtl/video_memory_bank_mapper_core.sv]
// Top level of the video memory bank mapper: input register, bank registers,
// lookup decode and result register. Depends on vmbm_pkg, vmbm_bank_file, vmbm_lookup.
//
// Usage: items arrive on the in_valid/in_ready channel. Opcode write stores a masked
// control byte for the bank named by bank_index (an index above eight is ignored);
// opcode lookup returns in hit_mask the banks that cover region_address in region_id.
// Every item produces exactly one result on the out_valid/out_ready channel, carrying
// stored_control, hit_mask and the sub-processor status of banks C and D after the item.
// An item passes through the input register and then the result register. Throughput is
// one item per cycle while the receiver does not stall; the single pass of nine parallel
// window compares sets that figure.
// Reset clears every bank control byte (all banks disabled) and empties both stages.
// When the receiver stalls, the result register holds and the input register holds
// one more item; in_ready drops only when both are full and out_ready is low.
`timescale 1ns / 1ps

module video_memory_bank_mapper_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [3:0]  bank_index,
  input  logic [7:0]  control_value,
  input  logic [3:0]  region_id,
  input  logic [19:0] region_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  stored_control,
  output logic [8:0]  hit_mask,
  output logic [1:0]  sub_cpu_status
);

  logic        s1_valid;
  logic        s1_opcode;
  logic [3:0]  s1_bank_index;
  logic [7:0]  s1_control_value;
  logic [3:0]  s1_region_id;
  logic [19:0] s1_region_address;

  logic                advance;
  logic                s1_write_ok;
  vmbm_pkg::bank_wr_t  wr;
  vmbm_pkg::ctl_bank_t controls;
  vmbm_pkg::ctl_t      masked_value;
  logic [1:0]          status_next;
  vmbm_pkg::hit_t      hits;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  assign s1_write_ok = (s1_opcode == vmbm_pkg::OP_WRITE)
                       && (s1_bank_index < 4'(vmbm_pkg::BANK_COUNT));

  // Bank registers change at the same edge that loads the result, so the next
  // item in the input register always sees the updated state.
  assign wr.en    = advance && s1_write_ok;
  assign wr.index = s1_bank_index;
  assign wr.value = s1_control_value;

  vmbm_bank_file u_bank_file (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .controls     (controls),
    .masked_value (masked_value),
    .status_next  (status_next)
  );

  vmbm_lookup u_lookup (
    .controls       (controls),
    .region_id      (s1_region_id),
    .region_address (s1_region_address),
    .hits           (hits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode         <= opcode;
      s1_bank_index     <= bank_index;
      s1_control_value  <= control_value;
      s1_region_id      <= region_id;
      s1_region_address <= region_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stored_control <= s1_write_ok ? masked_value : 8'h00;
      hit_mask       <= (s1_opcode == vmbm_pkg::OP_LOOKUP) ? hits : '0;
      sub_cpu_status <= status_next;
    end
  end

endmodule

[rtl/vmbm_checker.sv]
// Port-level checker for the video memory bank mapper, bound to the top level.
// Depends on video_memory_bank_mapper_core.
`timescale 1ns / 1ps

module vmbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  stored_control,
  input logic [8:0]  hit_mask,
  input logic [1:0]  sub_cpu_status
);

  // The result stage is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result presented straight after reset");

  // A result is either from a write or from a lookup, never both.
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stored_control != 8'h00) |-> (hit_mask == 9'h000))
    else $error("result carries both a stored byte and hits");

  // An accepting receiver never holds up the input side.
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while the receiver accepts");

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(stored_control) && $stable(hit_mask) && $stable(sub_cpu_status)))
    else $error("stalled result changed");

endmodule

bind video_memory_bank_mapper_core vmbm_checker u_vmbm_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .stored_control (stored_control),
  .hit_mask       (hit_mask),
  .sub_cpu_status (sub_cpu_status)
);

[tb/sv/tb_top.sv]
// Self-checking testbench for video_memory_bank_mapper_core: directed and random bank
// writes and region lookups, checked against a bank decode kept here in the testbench.
// Depends on vmbm_pkg and the RTL of the mapper core.
`timescale 1ns / 1ps

module tb_top;

  localparam int N_RANDOM       = 1175;
  localparam int TAIL_ITEMS     = 120;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_ADDR       = 'hA3FFF;

  typedef struct packed {
    logic [7:0] stored;
    logic [8:0] hits;
    logic [1:0] status;
  } mapper_result_t;

  typedef struct packed {
    logic           op;
    logic [3:0]     bank;
    logic [7:0]     value;
    logic [3:0]     region;
    logic [19:0]    addr;
    logic           drain;
    mapper_result_t result;
  } mapper_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        opcode = vmbm_pkg::OP_WRITE;
  logic [3:0]  bank_index = '0;
  logic [7:0]  control_value = '0;
  logic [3:0]  region_id = '0;
  logic [19:0] region_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  stored_control;
  logic [8:0]  hit_mask;
  logic [1:0]  sub_cpu_status;

  vmbm_pkg::ctl_t bank_ctl [vmbm_pkg::BANK_COUNT];
  mapper_item_t   stim_q[$];
  mapper_result_t mapping_q[$];
  mapper_item_t   next_item;
  int             gap_left = 0;
  int             stall_left = 0;
  int             results_seen = 0;
  int             mismatches = 0;
  int             quiet_cycles = 0;

  video_memory_bank_mapper_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .bank_index     (bank_index),
    .control_value  (control_value),
    .region_id      (region_id),
    .region_address (region_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .stored_control (stored_control),
    .hit_mask       (hit_mask),
    .sub_cpu_status (sub_cpu_status)
  );

  always #5 clk = ~clk;

  function automatic vmbm_pkg::ctl_t bank_write_mask(input logic [3:0] b);
    case (b)
      vmbm_pkg::BANK_A, vmbm_pkg::BANK_B: return 8'h9b;
      vmbm_pkg::BANK_C, vmbm_pkg::BANK_D,
      vmbm_pkg::BANK_F, vmbm_pkg::BANK_G: return 8'h9f;
      vmbm_pkg::BANK_E:                   return 8'h87;
      default:                            return 8'h83;
    endcase
  endfunction

  // Region and byte window of one bank under a control byte; false when it maps nothing.
  function automatic logic bank_window(input logic [3:0] b, input vmbm_pkg::ctl_t c,
                                       output logic [3:0] rgn, output int base,
                                       output int span);
    logic [2:0] mode;
    int         ofs;
    logic       ok;
    mode = c[2:0];
    ofs  = int'(c[4:3]);
    rgn  = vmbm_pkg::REG_LCDC;
    base = 0;
    span = 0;
    ok   = 1'b1;
    if (!c[7]) begin
      ok = 1'b0;
    end else if (mode == vmbm_pkg::MODE_LCDC) begin
      case (b)
        vmbm_pkg::BANK_A: begin base = 'h00000; span = 'h20000; end
        vmbm_pkg::BANK_B: begin base = 'h20000; span = 'h20000; end
        vmbm_pkg::BANK_C: begin base = 'h40000; span = 'h20000; end
        vmbm_pkg::BANK_D: begin base = 'h60000; span = 'h20000; end
        vmbm_pkg::BANK_E: begin base = 'h80000; span = 'h10000; end
        vmbm_pkg::BANK_F: begin base = 'h90000; span = 'h4000; end
        vmbm_pkg::BANK_G: begin base = 'h94000; span = 'h4000; end
        vmbm_pkg::BANK_H: begin base = 'h98000; span = 'h8000; end
        default:          begin base = 'hA0000; span = 'h4000; end
      endcase
    end else begin
      case (b)
        vmbm_pkg::BANK_A, vmbm_pkg::BANK_B, vmbm_pkg::BANK_C, vmbm_pkg::BANK_D: begin
          span = 'h20000;
          case (mode)
            vmbm_pkg::MODE_1: begin rgn = vmbm_pkg::REG_BG_A; base = ofs * 'h20000; end
            vmbm_pkg::MODE_2: begin
              rgn  = (b == vmbm_pkg::BANK_A || b == vmbm_pkg::BANK_B)
                     ? vmbm_pkg::REG_OBJ_A : vmbm_pkg::REG_SUB_CPU;
              base = c[3] ? 'h20000 : 0;
            end
            vmbm_pkg::MODE_3: begin rgn = vmbm_pkg::REG_TEX; base = ofs * 'h20000; end
            vmbm_pkg::MODE_4: begin
              ok  = (b == vmbm_pkg::BANK_C || b == vmbm_pkg::BANK_D);
              rgn = (b == vmbm_pkg::BANK_C) ? vmbm_pkg::REG_BG_B : vmbm_pkg::REG_OBJ_B;
            end
            default: ok = 1'b0;
          endcase
        end
        vmbm_pkg::BANK_E: begin
          span = 'h10000;
          case (mode)
            vmbm_pkg::MODE_1: rgn = vmbm_pkg::REG_BG_A;
            vmbm_pkg::MODE_2: rgn = vmbm_pkg::REG_OBJ_A;
            vmbm_pkg::MODE_3: rgn = vmbm_pkg::REG_TEX_PAL;
            vmbm_pkg::MODE_4: begin rgn = vmbm_pkg::REG_BG_A_EXT; span = 'h8000; end
            default:          ok = 1'b0;
          endcase
        end
        vmbm_pkg::BANK_F, vmbm_pkg::BANK_G: begin
          span = 'h4000;
          base = (c[3] ? 'h4000 : 0) + (c[4] ? 'h10000 : 0);
          case (mode)
            vmbm_pkg::MODE_1: rgn = vmbm_pkg::REG_BG_A;
            vmbm_pkg::MODE_2: rgn = vmbm_pkg::REG_OBJ_A;
            vmbm_pkg::MODE_3: rgn = vmbm_pkg::REG_TEX_PAL;
            vmbm_pkg::MODE_4: begin
              rgn  = vmbm_pkg::REG_BG_A_EXT;
              base = c[3] ? 'h4000 : 0;
            end
            vmbm_pkg::MODE_5: begin
              rgn  = vmbm_pkg::REG_OBJ_A_EXT;
              base = 0;
              span = 'h2000;
            end
            default: ok = 1'b0;
          endcase
        end
        vmbm_pkg::BANK_H: begin
          span = 'h8000;
          case (mode)
            vmbm_pkg::MODE_1: rgn = vmbm_pkg::REG_BG_B;
            vmbm_pkg::MODE_2: rgn = vmbm_pkg::REG_BG_B_EXT;
            default:          ok = 1'b0;
          endcase
        end
        default: begin
          span = 'h4000;
          case (mode)
            vmbm_pkg::MODE_1: begin rgn = vmbm_pkg::REG_BG_B; base = 'h8000; end
            vmbm_pkg::MODE_2: rgn = vmbm_pkg::REG_OBJ_B;
            vmbm_pkg::MODE_3: begin rgn = vmbm_pkg::REG_OBJ_B_EXT; span = 'h2000; end
            default:          ok = 1'b0;
          endcase
        end
      endcase
    end
    return ok;
  endfunction

  // Applies one item to the bank control bytes and returns the result it should give.
  function automatic mapper_result_t step_mapper(input mapper_item_t it);
    mapper_result_t r;
    logic [3:0]     rgn;
    int             base;
    int             span;
    int             b;
    r = '0;
    if (it.op == vmbm_pkg::OP_WRITE) begin
      if (it.bank <= vmbm_pkg::BANK_I) begin
        bank_ctl[it.bank] = it.value & bank_write_mask(it.bank);
        r.stored = bank_ctl[it.bank];
      end
    end else begin
      for (b = 0; b < vmbm_pkg::BANK_COUNT; b++) begin
        if (bank_window(4'(b), bank_ctl[b], rgn, base, span) && rgn == it.region &&
            int'(it.addr) >= base && int'(it.addr) - base < span)
          r.hits[b] = 1'b1;
      end
    end
    r.status[0] = bank_ctl[vmbm_pkg::BANK_C][7] &&
                  bank_ctl[vmbm_pkg::BANK_C][2:0] == vmbm_pkg::MODE_2;
    r.status[1] = bank_ctl[vmbm_pkg::BANK_D][7] &&
                  bank_ctl[vmbm_pkg::BANK_D][2:0] == vmbm_pkg::MODE_2;
    return r;
  endfunction

  // Fields that an operation does not use carry random junk.
  task automatic queue_write(input logic [3:0] bank, input logic [7:0] value,
                             input logic drain);
    mapper_item_t it;
    it        = '0;
    it.op     = vmbm_pkg::OP_WRITE;
    it.bank   = bank;
    it.value  = value;
    it.region = 4'($urandom_range(0, 15));
    it.addr   = 20'($urandom());
    it.drain  = drain;
    it.result = step_mapper(it);
    stim_q.push_back(it);
  endtask

  task automatic queue_lookup(input logic [3:0] region, input int addr, input logic drain);
    mapper_item_t it;
    it        = '0;
    it.op     = vmbm_pkg::OP_LOOKUP;
    it.bank   = 4'($urandom_range(0, 15));
    it.value  = 8'($urandom());
    it.region = region;
    it.addr   = 20'(addr);
    it.drain  = drain;
    it.result = step_mapper(it);
    stim_q.push_back(it);
  endtask

  initial begin
    int         i;
    int         b;
    int         base;
    int         span;
    int         addr;
    logic [3:0] rgn;
    logic [7:0] value;
    logic       drain;
    for (i = 0; i < vmbm_pkg::BANK_COUNT; i++) bank_ctl[i] = '0;

    queue_lookup(vmbm_pkg::REG_LCDC, 0, 1'b0);          // every bank disabled
    queue_write(4'd15, 8'hff, 1'b0);                    // index past bank I is ignored
    queue_write(vmbm_pkg::BANK_A, 8'hff, 1'b0);
    queue_write(vmbm_pkg::BANK_A, 8'h81, 1'b0);
    queue_write(vmbm_pkg::BANK_B, 8'h81, 1'b0);
    queue_lookup(vmbm_pkg::REG_BG_A, 'h00100, 1'b0);    // A and B overlap, both reported
    queue_write(vmbm_pkg::BANK_A, 8'h80, 1'b0);
    queue_write(vmbm_pkg::BANK_B, 8'h80, 1'b0);
    queue_write(vmbm_pkg::BANK_C, 8'h82, 1'b0);
    queue_write(vmbm_pkg::BANK_D, 8'h8a, 1'b0);
    queue_write(vmbm_pkg::BANK_E, 8'h84, 1'b0);
    queue_write(vmbm_pkg::BANK_F, 8'h85, 1'b0);
    queue_write(vmbm_pkg::BANK_G, 8'h9b, 1'b0);
    queue_write(vmbm_pkg::BANK_H, 8'h80, 1'b0);
    queue_write(vmbm_pkg::BANK_I, 8'h83, 1'b0);
    queue_lookup(vmbm_pkg::REG_LCDC, 'h1ffff, 1'b0);
    queue_lookup(vmbm_pkg::REG_LCDC, 'h20000, 1'b0);
    queue_lookup(vmbm_pkg::REG_LCDC, 'h9ffff, 1'b0);
    queue_lookup(vmbm_pkg::REG_LCDC, MAX_ADDR, 1'b0);   // no LCDC window is mapped here
    queue_lookup(vmbm_pkg::REG_SUB_CPU, 'h20000, 1'b0);
    queue_lookup(vmbm_pkg::REG_SUB_CPU, 'h1ffff, 1'b0);
    queue_lookup(vmbm_pkg::REG_TEX_PAL, 'h14000, 1'b0);
    queue_lookup(vmbm_pkg::REG_OBJ_A_EXT, 'h1fff, 1'b0);
    queue_lookup(4'd15, 0, 1'b0);                       // region code with no meaning
    queue_write(vmbm_pkg::BANK_E, 8'h87, 1'b0);         // mode with no meaning for bank E
    queue_lookup(vmbm_pkg::REG_BG_A_EXT, 0, 1'b0);
    queue_write(vmbm_pkg::BANK_H, 8'hff, 1'b0);
    queue_write(vmbm_pkg::BANK_C, 8'h7f, 1'b0);         // disabled, sub-processor bit clears

    for (i = 0; i < N_RANDOM; i++) begin
      drain = (i == 0 || i == 400 || i == 800);
      if ($urandom_range(0, 99) < 30) begin
        value = 8'($urandom());
        value[7] = $urandom_range(0, 99) < 85;
        if ($urandom_range(0, 19) == 0)
          queue_write(4'($urandom_range(9, 15)), value, drain);
        else
          queue_write(4'($urandom_range(0, 8)), value, drain);
      end else begin
        b = $urandom_range(0, 8);
        if (bank_window(4'(b), bank_ctl[b], rgn, base, span) &&
            $urandom_range(0, 9) < 8) begin
          case ($urandom_range(0, 4))
            0:       addr = base;
            1:       addr = base + span - 1;
            2:       addr = base + span;
            3:       addr = (base == 0) ? 1 : base - 1;
            default: addr = base + $urandom_range(0, span - 1);
          endcase
          if (addr > MAX_ADDR) addr = MAX_ADDR;
        end else begin
          rgn  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                             : 4'($urandom_range(0, 11));
          addr = $urandom_range(0, MAX_ADDR);
        end
        queue_lookup(rgn, addr, drain);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (stim_q.size() != 0 || in_valid || mapping_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS video_memory_bank_mapper_core");
    end else begin
      $display("FAIL video_memory_bank_mapper_core");
    end
    $finish;
  end

  // Sender: expectations are queued when an item is presented, which keeps them in
  // transfer order since a presented item is held until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (stim_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (stim_q[0].drain && mapping_q.size() != 0) begin
        in_valid <= 1'b0;
      end else if (stim_q.size() > TAIL_ITEMS &&
                   $urandom_range(0, 99) < ((stim_q.size() / 100) % 4) * 20) begin
        gap_left = $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else begin
        next_item = stim_q.pop_front();
        mapping_q.push_back(next_item.result);
        in_valid       <= 1'b1;
        opcode         <= next_item.op;
        bank_index     <= next_item.bank;
        control_value  <= next_item.value;
        region_id      <= next_item.region;
        region_address <= next_item.addr;
      end
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    mapper_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (mapping_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result transfer with nothing expected: stored %h hits %h sub %h",
                     $time, stored_control, hit_mask, sub_cpu_status);
        end else begin
          want = mapping_q.pop_front();
          if (stored_control !== want.stored || hit_mask !== want.hits ||
              sub_cpu_status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: stored %h/%h hits %h/%h sub %h/%h (expected/actual)",
                       $time, want.stored, stored_control, want.hits, hit_mask,
                       want.status, sub_cpu_status);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (stim_q.size() > TAIL_ITEMS &&
                   $urandom_range(0, 99) < ((results_seen / 130) % 4) * 15) begin
        stall_left = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Ends the run when neither channel has moved a transfer for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL video_memory_bank_mapper_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
